@@ rtl/sfr_pkg.sv @@
// Package for the stuffed frame receiver.
// Holds byte codes, parser states, command and status codes; no dependencies.
package sfr_pkg;

    localparam logic [7:0] FLAG_BYTE  = 8'h7E;
    localparam logic [7:0] ESC_BYTE   = 8'h7D;
    localparam logic [7:0] STUFF_MASK = 8'h20;
    localparam logic [7:0] CTRL_SEQ0  = 8'h00;
    localparam logic [7:0] CTRL_SEQ1  = 8'h80;
    localparam logic [7:0] RR_BASE    = 8'hAA;
    localparam logic [7:0] REJ_BASE   = 8'h54;

    localparam logic [7:0] PEER_ADDRESS_RESET  = 8'h03;
    localparam logic [7:0] REPLY_ADDRESS_RESET = 8'h01;

    localparam int          CFG_INDEX_W       = 8;
    localparam logic [7:0]  REG_PEER_ADDRESS  = 8'd0;
    localparam logic [7:0]  REG_REPLY_ADDRESS = 8'd1;

    localparam int          LEN_W             = 11;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_REPORT  = 1'b1;

    typedef enum logic [2:0] {
        PS_HUNT = 3'd0,
        PS_FLAG = 3'd1,
        PS_ADDR = 3'd2,
        PS_CTRL = 3'd3,
        PS_READ = 3'd4,
        PS_ESC  = 3'd5
    } t_parse_state;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_DATA  = 2'd1,
        CMD_END   = 2'd2
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind  kind;
        logic [7:0] data;
    } t_cmd;

    typedef enum logic [1:0] {
        FS_ACCEPTED  = 2'd0,
        FS_DUPLICATE = 2'd1,
        FS_BCC_ERROR = 2'd2,
        FS_REJECTED  = 2'd3
    } t_frame_status;

endpackage

@@ rtl/stuffed_frame_receiver_unit.sv @@
// Top level of the stuffed frame receiver.
// Instantiates sfr_front, sfr_back and two sfr_fifo queues; depends on sfr_pkg.
//
// Input channel: push and full. One received line byte per transfer; the
// front parser hunts for flag, address, control and header check, removes
// escape stuffing and hands commands to a two-entry queue.
// Result channel: empty and pop. Each result is a payload byte (kind 0) or an
// end of frame report (kind 1) with status, payload length and reply control.
// Payload bytes stream out before the frame is checked; drop them unless the
// report says accepted new.
// Configuration: cfg_valid / cfg_ready with index and data; index 0 sets the
// peer address, index 1 the reply address. Ready is always high.
// Throughput: one byte per cycle while full is low; the back part handles one
// command per cycle while the result queue has room. Path: a taken byte passes
// through the command queue and the back part into the result queue registers.
// Stall: when results are not popped the result queue fills, the back part
// holds, the command queue fills and full rises.
// Reset: parser hunts for a flag, expected sequence is one, queues empty,
// registers take their reset values.
module stuffed_frame_receiver_unit #(
    parameter int MAX_PAYLOAD = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic [7:0]                       i_rx_byte,
    output logic                             empty,
    input  logic                             pop,
    output logic                             o_result_kind,
    output logic [7:0]                       o_payload_byte,
    output logic [1:0]                       o_frame_status,
    output logic [sfr_pkg::LEN_W-1:0]        o_payload_length,
    output logic [7:0]                       o_reply_control,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [sfr_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [7:0]                       i_cfg_data
);
    import sfr_pkg::*;

    localparam int CMD_W = $bits(t_cmd);
    localparam int RES_W = 1 + 8 + 2 + LEN_W + 8;

    logic [7:0]       r_peer_address;
    logic [7:0]       r_reply_address;
    logic             in_take;
    logic             cmd_valid_f;
    t_cmd             cmd_f, cmd_b;
    logic [CMD_W-1:0] cmd_q;
    logic             cmd_empty, cmd_pop;
    logic             res_full, res_push;
    logic             res_kind;
    logic [7:0]       res_payload, res_reply;
    logic [1:0]       res_status;
    logic [LEN_W-1:0] res_length;
    logic [RES_W-1:0] res_q;

    assign o_cfg_ready = 1'b1;
    assign in_take     = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peer_address  <= PEER_ADDRESS_RESET;
            r_reply_address <= REPLY_ADDRESS_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == REG_PEER_ADDRESS) begin
                r_peer_address <= i_cfg_data;
            end else if (i_cfg_index == REG_REPLY_ADDRESS) begin
                r_reply_address <= i_cfg_data;
            end
        end
    end

    sfr_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (in_take),
        .i_byte         (i_rx_byte),
        .i_peer_address (r_peer_address),
        .o_cmd_valid    (cmd_valid_f),
        .o_cmd          (cmd_f)
    );

    sfr_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (2)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_valid_f),
        .i_data  (cmd_f),
        .o_full  (full),
        .i_pop   (cmd_pop),
        .o_data  (cmd_q),
        .o_empty (cmd_empty)
    );

    assign cmd_b = t_cmd'(cmd_q);

    sfr_back #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (!cmd_empty),
        .i_cmd         (cmd_b),
        .o_cmd_pop     (cmd_pop),
        .i_res_ready   (!res_full),
        .o_res_push    (res_push),
        .o_res_kind    (res_kind),
        .o_res_payload (res_payload),
        .o_res_status  (res_status),
        .o_res_length  (res_length),
        .o_res_reply   (res_reply)
    );

    sfr_fifo #(
        .WIDTH (RES_W),
        .DEPTH (2)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  ({res_kind, res_payload, res_status, res_length, res_reply}),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_q),
        .o_empty (empty)
    );

    assign {o_result_kind, o_payload_byte, o_frame_status, o_payload_length,
            o_reply_control} = res_q;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_kind == KIND_PAYLOAD && !empty) |->
            (o_frame_status == FS_ACCEPTED && o_payload_length == '0 && o_reply_control == '0))
        else $error("payload transfer carries report fields");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_kind == KIND_REPORT && !empty && o_frame_status != FS_ACCEPTED) |->
            (o_payload_length == '0))
        else $error("length reported for a frame not accepted");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_kind == KIND_REPORT && !empty && r_reply_address == r_reply_address) |->
            (o_payload_byte == '0))
        else $error("report carries a payload byte");

endmodule

@@ rtl/sfr_fifo.sv @@
// Small register queue with registered storage and a count.
// Used between front and back and for results; no dependencies.
module sfr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr == r_rd))
        else $error("queue empty with pointers apart");

endmodule

@@ rtl/sfr_front.sv @@
// Front part: frame parser that checks the header and removes escape stuffing.
// Emits start, data and end commands; depends on sfr_pkg.
module sfr_front (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    input  logic [7:0]   i_byte,
    input  logic [7:0]   i_peer_address,
    output logic         o_cmd_valid,
    output sfr_pkg::t_cmd o_cmd
);
    import sfr_pkg::*;

    t_parse_state r_state, n_state;
    logic         r_seq, n_seq;
    logic         hdr_match;

    assign hdr_match = (i_byte == ({r_seq, 7'b0} ^ i_peer_address));

    always_comb begin
        n_state = r_state;
        n_seq   = r_seq;
        if (i_valid) begin
            case (r_state)
                PS_FLAG: begin
                    if (i_byte == i_peer_address) n_state = PS_ADDR;
                    else if (i_byte == FLAG_BYTE) n_state = PS_FLAG;
                    else                          n_state = PS_HUNT;
                end
                PS_ADDR: begin
                    if (i_byte inside {CTRL_SEQ0, CTRL_SEQ1}) begin
                        n_state = PS_CTRL;
                        n_seq   = i_byte[7];
                    end else if (i_byte == FLAG_BYTE) begin
                        n_state = PS_FLAG;
                    end else begin
                        n_state = PS_HUNT;
                    end
                end
                PS_CTRL: begin
                    if (hdr_match)                n_state = PS_READ;
                    else if (i_byte == FLAG_BYTE) n_state = PS_FLAG;
                    else                          n_state = PS_HUNT;
                end
                PS_READ: begin
                    if (i_byte == ESC_BYTE)       n_state = PS_ESC;
                    else if (i_byte == FLAG_BYTE) n_state = PS_HUNT;
                    else                          n_state = PS_READ;
                end
                PS_ESC: begin
                    n_state = PS_READ;
                end
                default: begin
                    n_state = (i_byte == FLAG_BYTE) ? PS_FLAG : PS_HUNT;
                end
            endcase
        end
    end

    always_comb begin
        o_cmd_valid = 1'b0;
        o_cmd.kind  = CMD_DATA;
        o_cmd.data  = i_byte;
        if (i_valid) begin
            case (r_state)
                PS_CTRL: begin
                    if (hdr_match) begin
                        o_cmd_valid = 1'b1;
                        o_cmd.kind  = CMD_START;
                        o_cmd.data  = {7'b0, r_seq};
                    end
                end
                PS_READ: begin
                    if (i_byte == FLAG_BYTE) begin
                        o_cmd_valid = 1'b1;
                        o_cmd.kind  = CMD_END;
                    end else if (i_byte != ESC_BYTE) begin
                        o_cmd_valid = 1'b1;
                    end
                end
                PS_ESC: begin
                    o_cmd_valid = 1'b1;
                    o_cmd.data  = i_byte ^ STUFF_MASK;
                end
                default: begin
                    o_cmd_valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= PS_HUNT;
            r_seq   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_seq   <= n_seq;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && r_state == PS_ESC) |=> (r_state == PS_READ))
        else $error("escaped byte did not return to body");

endmodule

@@ rtl/sfr_back.sv @@
// Back part: holds one byte back, keeps the running XOR and count, builds reports.
// Takes commands from the front queue; depends on sfr_pkg.
module sfr_back #(
    parameter int MAX_PAYLOAD = 1024
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cmd_valid,
    input  sfr_pkg::t_cmd             i_cmd,
    output logic                      o_cmd_pop,
    input  logic                      i_res_ready,
    output logic                      o_res_push,
    output logic                      o_res_kind,
    output logic [7:0]                o_res_payload,
    output logic [1:0]                o_res_status,
    output logic [sfr_pkg::LEN_W-1:0] o_res_length,
    output logic [7:0]                o_res_reply
);
    import sfr_pkg::*;

    localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);

    logic             r_exp_seq, n_exp_seq;
    logic             r_frame_seq, n_frame_seq;
    logic [7:0]       r_held, n_held;
    logic             r_held_valid, n_held_valid;
    logic [7:0]       r_xor, n_xor;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_ovf, n_ovf;
    logic             proc;

    assign proc      = i_cmd_valid && i_res_ready;
    assign o_cmd_pop = proc;

    always_comb begin
        n_exp_seq     = r_exp_seq;
        n_frame_seq   = r_frame_seq;
        n_held        = r_held;
        n_held_valid  = r_held_valid;
        n_xor         = r_xor;
        n_count       = r_count;
        n_ovf         = r_ovf;
        o_res_push    = 1'b0;
        o_res_kind    = KIND_PAYLOAD;
        o_res_payload = '0;
        o_res_status  = FS_ACCEPTED;
        o_res_length  = '0;
        o_res_reply   = '0;
        if (proc) begin
            case (i_cmd.kind)
                CMD_START: begin
                    n_frame_seq  = i_cmd.data[0];
                    n_held_valid = 1'b0;
                    n_xor        = '0;
                    n_count      = '0;
                    n_ovf        = 1'b0;
                end
                CMD_DATA: begin
                    if (r_held_valid) begin
                        if (r_count >= CNT_W'(MAX_PAYLOAD)) begin
                            n_ovf = 1'b1;
                        end else begin
                            n_xor         = r_xor ^ r_held;
                            n_count       = r_count + CNT_W'(1);
                            o_res_push    = 1'b1;
                            o_res_payload = r_held;
                        end
                    end
                    n_held       = i_cmd.data;
                    n_held_valid = 1'b1;
                end
                CMD_END: begin
                    o_res_push = 1'b1;
                    o_res_kind = KIND_REPORT;
                    if (!r_held_valid || r_ovf) begin
                        o_res_status = FS_REJECTED;
                        o_res_reply  = REJ_BASE | {7'b0, r_exp_seq};
                    end else if (r_held == r_xor) begin
                        o_res_reply = RR_BASE | {7'b0, r_exp_seq};
                        if (r_frame_seq != r_exp_seq) begin
                            o_res_status = FS_ACCEPTED;
                            o_res_length = LEN_W'(r_count);
                            n_exp_seq    = ~r_exp_seq;
                        end else begin
                            o_res_status = FS_DUPLICATE;
                        end
                    end else begin
                        o_res_status = FS_BCC_ERROR;
                        o_res_reply  = REJ_BASE | {7'b0, r_exp_seq};
                    end
                end
                default: begin
                    o_res_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_seq    <= 1'b1;
            r_frame_seq  <= 1'b0;
            r_held_valid <= 1'b0;
            r_xor        <= '0;
            r_count      <= '0;
            r_ovf        <= 1'b0;
        end else begin
            r_exp_seq    <= n_exp_seq;
            r_frame_seq  <= n_frame_seq;
            r_held_valid <= n_held_valid;
            r_xor        <= n_xor;
            r_count      <= n_count;
            r_ovf        <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        r_held <= n_held;
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_PAYLOAD))
        else $error("payload count beyond limit");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |-> i_res_ready)
        else $error("result transfer into a full queue");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && i_cmd.kind == CMD_START) |=> (!r_held_valid && r_count == '0 && !r_ovf))
        else $error("frame start did not clear frame state");

endmodule

@@ test/tb_stuffed_frame_receiver_unit.sv @@
// Testbench for stuffed_frame_receiver_unit: feeds line bytes through push/full,
// predicts payload bytes and frame reports, and checks every popped result.
// Depends on sfr_pkg and the receiver RTL; self-contained otherwise.
`timescale 1ns / 100ps

module tb_stuffed_frame_receiver_unit;
    import sfr_pkg::*;

    localparam int MAX_PAYLOAD   = 1024;
    localparam int SETTLE_CYCLES = 16;
    localparam int LIMIT_NS      = 2_000_000;

    typedef struct {
        logic              kind;
        logic [7:0]        data;
        t_frame_status     status;
        logic [LEN_W-1:0]  length;
        logic [7:0]        reply;
    } t_frame_result;

    class t_rx_frame_tracker;
        logic [7:0]     peer_address_q;
        logic [7:0]     reply_address_q;
        t_parse_state   parse_q;
        logic           seq_bit_q;
        logic           expect_seq_q;
        logic [7:0]     held_q;
        logic           held_ok_q;
        logic [7:0]     xor_q;
        int unsigned    count_q;
        logic           overflow_q;
        t_frame_result  pending_results[$];
        int             failures;

        function new();
            peer_address_q  = PEER_ADDRESS_RESET;
            reply_address_q = REPLY_ADDRESS_RESET;
            parse_q         = PS_HUNT;
            seq_bit_q       = 1'b0;
            expect_seq_q    = 1'b1;
            held_q          = 8'h00;
            held_ok_q       = 1'b0;
            xor_q           = 8'h00;
            count_q         = 0;
            overflow_q      = 1'b0;
            failures        = 0;
        endfunction

        function void set_register(logic [7:0] idx, logic [7:0] value);
            if (idx == REG_PEER_ADDRESS) begin
                peer_address_q = value;
            end else if (idx == REG_REPLY_ADDRESS) begin
                reply_address_q = value;
            end
        endfunction

        function void release_body_byte(logic [7:0] d);
            t_frame_result r;
            if (held_ok_q) begin
                if (count_q >= MAX_PAYLOAD) begin
                    overflow_q = 1'b1;
                end else begin
                    xor_q    = xor_q ^ held_q;
                    count_q++;
                    r.kind   = KIND_PAYLOAD;
                    r.data   = held_q;
                    r.status = FS_ACCEPTED;
                    r.length = '0;
                    r.reply  = 8'h00;
                    pending_results.push_back(r);
                end
            end
            held_q    = d;
            held_ok_q = 1'b1;
        endfunction

        function void close_frame();
            t_frame_result r;
            r.kind   = KIND_REPORT;
            r.data   = 8'h00;
            r.length = '0;
            if (!held_ok_q || overflow_q) begin
                r.status = FS_REJECTED;
                r.reply  = REJ_BASE | {7'd0, expect_seq_q};
            end else if (held_q == xor_q) begin
                r.reply = RR_BASE | {7'd0, expect_seq_q};
                if (seq_bit_q != expect_seq_q) begin
                    r.status     = FS_ACCEPTED;
                    r.length     = count_q[LEN_W-1:0];
                    expect_seq_q = ~expect_seq_q;
                end else begin
                    r.status = FS_DUPLICATE;
                end
            end else begin
                r.status = FS_BCC_ERROR;
                r.reply  = REJ_BASE | {7'd0, expect_seq_q};
            end
            pending_results.push_back(r);
            parse_q = PS_HUNT;
        endfunction

        function void note_rx_byte(logic [7:0] b);
            case (parse_q)
                PS_FLAG: begin
                    if (b == peer_address_q) parse_q = PS_ADDR;
                    else if (b == FLAG_BYTE) parse_q = PS_FLAG;
                    else parse_q = PS_HUNT;
                end
                PS_ADDR: begin
                    if (b == CTRL_SEQ0 || b == CTRL_SEQ1) begin
                        seq_bit_q = b[7];
                        parse_q   = PS_CTRL;
                    end else if (b == FLAG_BYTE) begin
                        parse_q = PS_FLAG;
                    end else begin
                        parse_q = PS_HUNT;
                    end
                end
                PS_CTRL: begin
                    if (b == ({seq_bit_q, 7'd0} ^ peer_address_q)) begin
                        parse_q    = PS_READ;
                        held_q     = 8'h00;
                        held_ok_q  = 1'b0;
                        xor_q      = 8'h00;
                        count_q    = 0;
                        overflow_q = 1'b0;
                    end else if (b == FLAG_BYTE) begin
                        parse_q = PS_FLAG;
                    end else begin
                        parse_q = PS_HUNT;
                    end
                end
                PS_READ: begin
                    if (b == ESC_BYTE) parse_q = PS_ESC;
                    else if (b == FLAG_BYTE) close_frame();
                    else release_body_byte(b);
                end
                PS_ESC: begin
                    parse_q = PS_READ;
                    release_body_byte(b ^ STUFF_MASK);
                end
                default: begin
                    parse_q = (b == FLAG_BYTE) ? PS_FLAG : PS_HUNT;
                end
            endcase
        endfunction

        function string describe(t_frame_result r);
            return $sformatf("kind %0d byte %02h status %0d length %0d control %02h",
                             r.kind, r.data, r.status, r.length, r.reply);
        endfunction

        function void note_failure(string msg);
            failures++;
            if (failures <= 10) $display("mismatch at %0t: %s", $realtime, msg);
        endfunction

        function void check_result(t_frame_result got);
            t_frame_result want;
            if (pending_results.size() == 0) begin
                note_failure({"unexpected result ", describe(got)});
                return;
            end
            want = pending_results.pop_front();
            if (got.kind !== want.kind || got.data !== want.data ||
                got.status !== want.status || got.length !== want.length ||
                got.reply !== want.reply) begin
                note_failure({"expected ", describe(want), ", got ", describe(got)});
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               push;
    logic               full;
    logic [7:0]         i_rx_byte;
    logic               empty;
    logic               pop;
    logic               o_result_kind;
    logic [7:0]         o_payload_byte;
    logic [1:0]         o_frame_status;
    logic [LEN_W-1:0]   o_payload_length;
    logic [7:0]         o_reply_control;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [7:0]         i_cfg_data;

    t_rx_frame_tracker tracker = new();
    int burst_left = 0;
    int gap_max    = 0;
    int bytes_sent = 0;

    stuffed_frame_receiver_unit #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_rx_byte        (i_rx_byte),
        .empty            (empty),
        .pop              (pop),
        .o_result_kind    (o_result_kind),
        .o_payload_byte   (o_payload_byte),
        .o_frame_status   (o_frame_status),
        .o_payload_length (o_payload_length),
        .o_reply_control  (o_reply_control),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #(LIMIT_NS);
        $display("FAIL");
        $finish;
    end

    // Result side: pop on a rotating stall mask, re-drawn from all-ones, random, sparse, one-bit and one-hole patterns.
    initial begin
        logic [15:0]   stall_mask;
        int            tick;
        t_frame_result got;
        pop        = 1'b0;
        stall_mask = '1;
        tick       = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty) begin
                got.kind   = o_result_kind;
                got.data   = o_payload_byte;
                got.status = t_frame_status'(o_frame_status);
                got.length = o_payload_length;
                got.reply  = o_reply_control;
                tracker.check_result(got);
            end
            if (tick % 200 == 0) begin
                case ($urandom_range(0, 5))
                    0, 1: stall_mask = '1;
                    2: stall_mask = 16'($urandom);
                    3: stall_mask = 16'($urandom & $urandom);
                    4: stall_mask = 16'h0001 << $urandom_range(0, 15);
                    default: stall_mask = ~(16'h0001 << $urandom_range(0, 15));
                endcase
            end
            pop <= stall_mask[tick % 16];
            tick++;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        push      <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (full);
        tracker.note_rx_byte(b);
        bytes_sent++;
    endtask

    task automatic write_register(input logic [7:0] idx, input logic [7:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        tracker.set_register(idx, value);
    endtask

    // Hold the line until every predicted result has been popped, then settle.
    task automatic wait_drained();
        push <= 1'b0;
        while (tracker.pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [7:0] biased_byte();
        case ($urandom_range(0, 15))
            0: return FLAG_BYTE;
            1: return ESC_BYTE;
            2: return tracker.peer_address_q;
            3: return FLAG_BYTE ^ STUFF_MASK;
            4: return ESC_BYTE ^ STUFF_MASK;
            5: return CTRL_SEQ1;
            default: return 8'($urandom);
        endcase
    endfunction

    // Send one frame; a non-negative payload size forces a clean frame of that size.
    task automatic send_frame(input int forced_len);
        logic [7:0] line[$];
        logic [7:0] body[$];
        int         pick;
        int         len;
        int         pos;
        logic       seq;
        logic [7:0] ctrl;
        logic [7:0] bcc;
        logic [7:0] d;
        pick = (forced_len < 0) ? $urandom_range(0, 99) : 99;
        if (pick < 6) begin
            repeat ($urandom_range(1, 6)) line.push_back(biased_byte());
        end else begin
            seq = ($urandom_range(0, 9) < 7 || forced_len >= 0) ?
                  ~tracker.expect_seq_q : tracker.expect_seq_q;
            ctrl = seq ? CTRL_SEQ1 : CTRL_SEQ0;
            line = {FLAG_BYTE, tracker.peer_address_q, ctrl, ctrl ^ tracker.peer_address_q};
            if (pick < 14) begin
                pos = $urandom_range(1, 3);
                if ($urandom_range(0, 1)) line[pos] = FLAG_BYTE;
                else line[pos] = line[pos] ^ 8'($urandom_range(1, 255));
            end
            if (pick >= 14 && pick < 19) begin
                line.push_back(FLAG_BYTE);
            end else begin
                if (forced_len >= 0) len = forced_len;
                else if ($urandom_range(0, 3) == 0) len = $urandom_range(0, 64);
                else len = $urandom_range(0, 12);
                bcc = 8'h00;
                repeat (len) begin
                    d = biased_byte();
                    bcc ^= d;
                    body.push_back(d);
                end
                if (forced_len < 0 && $urandom_range(0, 99) < 12) bcc ^= 8'($urandom_range(1, 255));
                body.push_back(bcc);
                foreach (body[i]) begin
                    if (body[i] == FLAG_BYTE || body[i] == ESC_BYTE ||
                        $urandom_range(0, 99) < 4) begin
                        line.push_back(ESC_BYTE);
                        line.push_back(body[i] ^ STUFF_MASK);
                    end else begin
                        line.push_back(body[i]);
                    end
                end
                // drop the closing flag now and then; the next opening flag closes it
                if (forced_len >= 0 || $urandom_range(0, 99) >= 3) line.push_back(FLAG_BYTE);
            end
        end
        foreach (line[i]) send_byte(line[i]);
    endtask

    initial begin
        logic [7:0] directed_bytes[$];
        logic [7:0] peer;
        logic [7:0] reply;
        int         target;
        i_rst_n     = 1'b0;
        push        = 1'b0;
        i_rx_byte   = 8'h00;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = 8'h00;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        directed_bytes = {
            FLAG_BYTE, FLAG_BYTE, PEER_ADDRESS_RESET, CTRL_SEQ1,
            PEER_ADDRESS_RESET ^ CTRL_SEQ1, FLAG_BYTE,
            FLAG_BYTE, PEER_ADDRESS_RESET, CTRL_SEQ0, FLAG_BYTE,
            PEER_ADDRESS_RESET, CTRL_SEQ0, PEER_ADDRESS_RESET ^ CTRL_SEQ0,
            ESC_BYTE, FLAG_BYTE ^ STUFF_MASK, ESC_BYTE, FLAG_BYTE ^ STUFF_MASK, FLAG_BYTE,
            FLAG_BYTE, PEER_ADDRESS_RESET, CTRL_SEQ0, PEER_ADDRESS_RESET ^ CTRL_SEQ0,
            8'h00, FLAG_BYTE,
            FLAG_BYTE, PEER_ADDRESS_RESET, CTRL_SEQ1, PEER_ADDRESS_RESET ^ CTRL_SEQ1,
            8'hFF, ESC_BYTE, ESC_BYTE ^ STUFF_MASK, 8'h00, FLAG_BYTE
        };
        gap_max = 4;
        foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
        wait_drained();

        for (int phase = 0; phase < 9; phase++) begin
            case (phase)
                0: peer = 8'h00;
                1: peer = 8'hFF;
                2: peer = FLAG_BYTE;
                3: peer = ESC_BYTE;
                4: peer = PEER_ADDRESS_RESET;
                default: peer = 8'($urandom);
            endcase
            case (phase)
                0: reply = 8'h00;
                1: reply = 8'hFF;
                default: reply = 8'($urandom);
            endcase
            write_register(REG_PEER_ADDRESS, peer);
            write_register(REG_REPLY_ADDRESS, reply);
            gap_max = (phase % 3 == 0) ? 0 : $urandom_range(2, 30);
            if (phase == 4) begin
                send_frame(MAX_PAYLOAD + 1);
            end
            target = bytes_sent + 40;
            while (bytes_sent < target) send_frame(-1);
            wait_drained();
        end

        if (tracker.failures == 0 && tracker.pending_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
